// File: sv/aeas_pkg.sv
// shared types, constants and sine lookup for the easy-axis search block
package aeas_pkg;

    // widths of the fixed word fields
    localparam int WORD_W           = 32;
    localparam int TENSOR_WIDTH_DEF = 32;
    localparam int SINE_ENTRIES     = 91;
    localparam int SINE_IDX_W       = 7;
    localparam int TRIG_W           = 16;
    localparam int TRIG_FRAC        = 15;
    localparam int MUL_W            = 32;
    localparam int PROD_W           = 64;
    localparam int MIN_W            = 48;
    localparam int E_SHIFT          = 30;
    localparam int POL_W            = 8;
    localparam int AZI_W            = 9;
    localparam int SWEEP_W          = 10;
    localparam int CFG_W            = 8;

    // sweep limits in degrees
    localparam logic [SWEEP_W-1:0] DEG_90  = 10'd90;
    localparam logic [SWEEP_W-1:0] DEG_180 = 10'd180;
    localparam logic [SWEEP_W-1:0] DEG_270 = 10'd270;
    localparam logic [SWEEP_W-1:0] DEG_360 = 10'd360;

    // grid step after reset
    localparam logic [CFG_W-1:0] STEP_RESET = 8'd5;

    // energy start bound, 10000.0 in Q16.16
    localparam logic signed [WORD_W-1:0] START_BOUND_Q16 = 32'sd655360000;
    localparam logic signed [MIN_W-1:0]  START_BOUND     = 48'sd655360000;

    // quarter-wave sine, Q1.15, top entry saturated
    localparam logic [TRIG_W-1:0] SINE_ROM [SINE_ENTRIES] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32767
    };

    // input word
    typedef struct packed {
        logic signed [WORD_W-1:0] k_xx;
        logic signed [WORD_W-1:0] k_xy;
        logic signed [WORD_W-1:0] k_xz;
        logic signed [WORD_W-1:0] k_yy;
        logic signed [WORD_W-1:0] k_yz;
        logic signed [WORD_W-1:0] k_zz;
        logic signed [WORD_W-1:0] site_height;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        [POL_W-1:0]  best_polar;
        logic        [AZI_W-1:0]  best_azimuth;
        logic signed [WORD_W-1:0] best_energy;
        logic signed [TRIG_W-1:0] axis_cosine;
        logic signed [WORD_W-1:0] height_echo;
        logic                     found;
    } t_out_word;

    // grid point angles
    typedef struct packed {
        logic [POL_W-1:0] polar;
        logic [AZI_W-1:0] azimuth;
    } t_angle;

    // trig values of one grid point
    typedef struct packed {
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sa;
        logic signed [TRIG_W-1:0] ca;
    } t_trig;

    // sine of a whole-degree angle below 450, folded by quadrant
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [SWEEP_W-1:0] d_in);
        logic [SWEEP_W-1:0]    d;
        logic [SINE_IDX_W-1:0] idx;
        logic                  neg;
        d = (d_in >= DEG_360) ? d_in - DEG_360 : d_in;
        priority if (d <= DEG_90) begin
            idx = d[SINE_IDX_W-1:0];
            neg = 1'b0;
        end else if (d <= DEG_180) begin
            idx = SINE_IDX_W'(DEG_180 - d);
            neg = 1'b0;
        end else if (d <= DEG_270) begin
            idx = SINE_IDX_W'(d - DEG_180);
            neg = 1'b1;
        end else begin
            idx = SINE_IDX_W'(DEG_360 - d);
            neg = 1'b1;
        end
        return neg ? -signed'(SINE_ROM[idx]) : signed'(SINE_ROM[idx]);
    endfunction

    // cosine as a quarter-turn shifted sine
    function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [SWEEP_W-1:0] d_in);
        logic [SWEEP_W-1:0] d;
        d = (d_in >= DEG_360) ? d_in - DEG_360 : d_in;
        return sin_deg(d + DEG_90);
    endfunction

endpackage

// File: sv/aeas_mul.sv
// shared signed multiplier with registered product
module aeas_mul (
    input  logic                                 i_clk,
    input  logic signed [aeas_pkg::MUL_W-1:0]    i_a,
    input  logic signed [aeas_pkg::MUL_W-1:0]    i_b,
    output logic signed [aeas_pkg::PROD_W-1:0]   o_prod
);
    import aeas_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: sv/aeas_trig.sv
// registered sine and cosine lookup for one grid point
module aeas_trig (
    input  logic             i_clk,
    input  logic             i_load,
    input  aeas_pkg::t_angle i_ang,
    output aeas_pkg::t_trig  o_trig
);
    import aeas_pkg::*;

    t_trig r_trig;

    // four rom reads, held for the whole point
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_trig.sp <= sin_deg(SWEEP_W'(i_ang.polar));
            r_trig.cp <= cos_deg(SWEEP_W'(i_ang.polar));
            r_trig.sa <= sin_deg(SWEEP_W'(i_ang.azimuth));
            r_trig.ca <= cos_deg(SWEEP_W'(i_ang.azimuth));
        end
    end

    assign o_trig = r_trig;

endmodule

// File: sv/anisotropy_easy_axis_search_top.sv
// top level: sweep sequencer, accumulator and minimum tracking
// Usage: drive i_item and raise start; the word is taken at the clock edge where
// start is high and busy is low. busy then stays high for the whole sweep.
// Grid step: write i_cfg_data with i_cfg_valid while the block is idle; o_cfg_ready
// is always high. A step of zero counts as one; reset loads a step of 5.
// Each grid point is worked through on one shared 32x32 multiplier: a trig
// lookup, two products for the in-plane direction, six quadratic terms each
// followed by its tensor product, a final add and the compare.
// With P = 180/s + 1 polar and A = 360/s + 1 azimuth points (integer division),
// the sweep covers P x A grid points, 1 x 2 for steps above 180. The result
// strobe o_result_strobe is raised from the finish state after the last compare.
// busy drops in the strobe cycle, so a new word may be
// started while the result is shown.
// o_result is valid for exactly one cycle with o_result_strobe; the receiver
// cannot stall it. Reset (synchronous, active low) returns to idle and drops
// any sweep in progress without a result.
module anisotropy_easy_axis_search_top #(
    parameter int TENSOR_WIDTH = aeas_pkg::TENSOR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  aeas_pkg::t_in_word          i_item,
    output logic                        o_result_strobe,
    output aeas_pkg::t_out_word         o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [aeas_pkg::CFG_W-1:0]  i_cfg_data
);
    import aeas_pkg::*;

    localparam int KW = (TENSOR_WIDTH >= WORD_W) ? WORD_W : TENSOR_WIDTH;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // steps within one grid point
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_LOOK     = 5'd0;
    localparam logic [STEP_W-1:0] ST_CA_SP    = 5'd1;
    localparam logic [STEP_W-1:0] ST_SA_SP    = 5'd2;
    localparam logic [STEP_W-1:0] ST_XX       = 5'd3;
    localparam logic [STEP_W-1:0] ST_K_XX     = 5'd4;
    localparam logic [STEP_W-1:0] ST_YY       = 5'd5;
    localparam logic [STEP_W-1:0] ST_K_YY     = 5'd6;
    localparam logic [STEP_W-1:0] ST_ZZ       = 5'd7;
    localparam logic [STEP_W-1:0] ST_K_ZZ     = 5'd8;
    localparam logic [STEP_W-1:0] ST_XY       = 5'd9;
    localparam logic [STEP_W-1:0] ST_K_XY     = 5'd10;
    localparam logic [STEP_W-1:0] ST_XZ       = 5'd11;
    localparam logic [STEP_W-1:0] ST_K_XZ     = 5'd12;
    localparam logic [STEP_W-1:0] ST_YZ       = 5'd13;
    localparam logic [STEP_W-1:0] ST_K_YZ     = 5'd14;
    localparam logic [STEP_W-1:0] ST_ACC_LAST = 5'd15;
    localparam logic [STEP_W-1:0] ST_CMP      = 5'd16;

    // tensor slots
    localparam int K_XX = 0;
    localparam int K_XY = 1;
    localparam int K_XZ = 2;
    localparam int K_YY = 3;
    localparam int K_YZ = 4;
    localparam int K_ZZ = 5;
    localparam int K_N  = 6;

    localparam logic signed [MUL_W-1:0]  X_HALF = MUL_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [PROD_W-1:0] E_HALF = PROD_W'(1) << (E_SHIFT - 1);
    localparam logic signed [MIN_W-1:0]  E_MAX  = 48'sd2147483647;
    localparam logic signed [MIN_W-1:0]  E_MIN  = -48'sd2147483648;

    logic [1:0]               r_state, n_state;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [POL_W-1:0]         r_pol, n_pol;
    logic [AZI_W-1:0]         r_azi, n_azi;
    logic [CFG_W-1:0]         r_cfg, n_cfg;
    logic                     r_found, n_found;
    logic                     r_strobe, n_strobe;
    logic signed [KW-1:0]     r_k [K_N];
    logic signed [KW-1:0]     n_k [K_N];
    logic signed [WORD_W-1:0] r_height, n_height;
    logic signed [TRIG_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic signed [MIN_W-1:0]  r_min, n_min;
    logic [POL_W-1:0]         r_min_pol, n_min_pol;
    logic [AZI_W-1:0]         r_min_azi, n_min_azi;
    t_out_word                r_res, n_res;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  prod32, prod2, rnd_sum;
    logic signed [MIN_W-1:0]  e_cur;
    logic [CFG_W-1:0]         step_eff;
    logic [SWEEP_W-1:0]       nxt_pol, nxt_azi;
    t_trig                    trig;
    t_angle                   ang;
    logic                     trig_load;

    // shared multiplier and trig lookup
    aeas_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign ang.polar   = r_pol;
    assign ang.azimuth = r_azi;
    assign trig_load   = (r_state == S_RUN) && (r_step == ST_LOOK);

    aeas_trig u_trig (
        .i_clk  (i_clk),
        .i_load (trig_load),
        .i_ang  (ang),
        .o_trig (trig)
    );

    // product views: low word, doubled cross term, rounded direction component
    assign prod32  = prod[MUL_W-1:0];
    assign prod2   = prod32 <<< 1;
    assign rnd_sum = prod32 + X_HALF;
    assign e_cur   = MIN_W'(r_acc >>> E_SHIFT);

    assign step_eff = (r_cfg == '0) ? CFG_W'(1) : r_cfg;
    assign nxt_pol  = SWEEP_W'(r_pol) + SWEEP_W'(step_eff);
    assign nxt_azi  = SWEEP_W'(r_azi) + SWEEP_W'(step_eff);

    // multiplier operand select per step
    always_comb begin
        unique case (r_step)
            ST_CA_SP: begin mul_a = MUL_W'(trig.ca);   mul_b = MUL_W'(trig.sp); end
            ST_SA_SP: begin mul_a = MUL_W'(trig.sa);   mul_b = MUL_W'(trig.sp); end
            ST_XX:    begin mul_a = MUL_W'(r_x);       mul_b = MUL_W'(r_x);     end
            ST_K_XX:  begin mul_a = MUL_W'(r_k[K_XX]); mul_b = prod32;          end
            ST_YY:    begin mul_a = MUL_W'(r_y);       mul_b = MUL_W'(r_y);     end
            ST_K_YY:  begin mul_a = MUL_W'(r_k[K_YY]); mul_b = prod32;          end
            ST_ZZ:    begin mul_a = MUL_W'(trig.cp);   mul_b = MUL_W'(trig.cp); end
            ST_K_ZZ:  begin mul_a = MUL_W'(r_k[K_ZZ]); mul_b = prod32;          end
            ST_XY:    begin mul_a = MUL_W'(r_x);       mul_b = MUL_W'(r_y);     end
            ST_K_XY:  begin mul_a = MUL_W'(r_k[K_XY]); mul_b = prod2;           end
            ST_XZ:    begin mul_a = MUL_W'(r_x);       mul_b = MUL_W'(trig.cp); end
            ST_K_XZ:  begin mul_a = MUL_W'(r_k[K_XZ]); mul_b = prod2;           end
            ST_YZ:    begin mul_a = MUL_W'(r_y);       mul_b = MUL_W'(trig.cp); end
            ST_K_YZ:  begin mul_a = MUL_W'(r_k[K_YZ]); mul_b = prod2;           end
            default:  begin mul_a = '0;                mul_b = '0;              end
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_pol     = r_pol;
        n_azi     = r_azi;
        n_cfg     = r_cfg;
        n_found   = r_found;
        n_strobe  = 1'b0;
        n_k       = r_k;
        n_height  = r_height;
        n_x       = r_x;
        n_y       = r_y;
        n_acc     = r_acc;
        n_min     = r_min;
        n_min_pol = r_min_pol;
        n_min_azi = r_min_azi;
        n_res     = r_res;

        // grid step write
        if (i_cfg_valid && o_cfg_ready) begin
            n_cfg = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state     = S_RUN;
                    n_step      = ST_LOOK;
                    n_pol       = '0;
                    n_azi       = '0;
                    n_found     = 1'b0;
                    n_min       = START_BOUND;
                    n_min_pol   = '0;
                    n_min_azi   = '0;
                    n_k[K_XX]   = i_item.k_xx[KW-1:0];
                    n_k[K_XY]   = i_item.k_xy[KW-1:0];
                    n_k[K_XZ]   = i_item.k_xz[KW-1:0];
                    n_k[K_YY]   = i_item.k_yy[KW-1:0];
                    n_k[K_YZ]   = i_item.k_yz[KW-1:0];
                    n_k[K_ZZ]   = i_item.k_zz[KW-1:0];
                    n_height    = i_item.site_height;
                end
            end
            S_RUN: begin
                n_step = r_step + STEP_W'(1);
                // direction components, rounded half up
                if (r_step == ST_SA_SP) begin
                    n_x = rnd_sum[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
                end
                if (r_step == ST_XX) begin
                    n_y = rnd_sum[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
                end
                // tensor products land on odd steps
                if (r_step == ST_YY) begin
                    n_acc = prod + E_HALF;
                end else if (r_step[0] && (r_step > ST_YY) && (r_step <= ST_ACC_LAST)) begin
                    n_acc = r_acc + prod;
                end
                // strict compare, then next grid point
                if (r_step == ST_CMP) begin
                    n_step = ST_LOOK;
                    if (e_cur < r_min) begin
                        n_min     = e_cur;
                        n_min_pol = r_pol;
                        n_min_azi = r_azi;
                        n_found   = 1'b1;
                    end
                    if (nxt_azi > DEG_360) begin
                        n_azi = '0;
                        if (nxt_pol > DEG_180) begin
                            n_state = S_FIN;
                        end else begin
                            n_pol = nxt_pol[POL_W-1:0];
                        end
                    end else begin
                        n_azi = nxt_azi[AZI_W-1:0];
                    end
                end
            end
            S_FIN: begin
                n_state              = S_IDLE;
                n_strobe             = 1'b1;
                n_res.best_polar     = r_min_pol;
                n_res.best_azimuth   = r_min_azi;
                n_res.height_echo    = r_height;
                n_res.found          = r_found;
                n_res.axis_cosine    = r_found ? cos_deg(SWEEP_W'(r_min_pol)) : '0;
                priority if (r_min > E_MAX) begin
                    n_res.best_energy = WORD_W'(E_MAX);
                end else if (r_min < E_MIN) begin
                    n_res.best_energy = WORD_W'(E_MIN);
                end else begin
                    n_res.best_energy = WORD_W'(r_min);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_LOOK;
            r_pol    <= '0;
            r_azi    <= '0;
            r_cfg    <= STEP_RESET;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_pol    <= n_pol;
            r_azi    <= n_azi;
            r_cfg    <= n_cfg;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_height  <= n_height;
        r_x       <= n_x;
        r_y       <= n_y;
        r_acc     <= n_acc;
        r_min     <= n_min;
        r_min_pol <= n_min_pol;
        r_min_azi <= n_min_azi;
        r_res     <= n_res;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;
    assign o_cfg_ready     = 1'b1;

endmodule

// File: sv/aeas_checker.sv
// port-level checks for the easy-axis search block, with bind
module aeas_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_strobe,
    input aeas_pkg::t_out_word  o_result
);
    import aeas_pkg::*;

    // an accepted word starts a sweep
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    // busy only drops together with a result
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_result_strobe)
        else $error("sweep ended without result strobe");

    // strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

    // nothing below the bound reports the bound and zero angles
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.found |->
            (o_result.best_energy == START_BOUND_Q16) && (o_result.axis_cosine == '0)
            && (o_result.best_polar == '0) && (o_result.best_azimuth == '0))
        else $error("empty search result not at start bound");

endmodule

bind anisotropy_easy_axis_search_top aeas_checker u_aeas_checker (.*);

// File: tb/sv/aeas_result_checker.sv
// result checker for the easy-axis search: predicts each sweep and compares result words
`timescale 1ns / 1ps
module aeas_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  aeas_pkg::t_in_word          i_item,
    input  logic                        i_result_strobe,
    input  aeas_pkg::t_out_word         i_result,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [aeas_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_failures,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_found
);
    import aeas_pkg::*;

    // quarter-wave sine in Q1.15, top entry held at 32767
    localparam int QUARTER_SINE [91] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32767
    };

    localparam longint ENERGY_BOUND = 64'sd655360000;
    localparam longint HALF_Q15     = 64'sd16384;
    localparam longint HALF_ENERGY  = 64'sd536870912;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;
    localparam int     SHOWN_LIMIT  = 10;

    logic [CFG_W-1:0] grid_step;
    t_out_word        pending_minima [$];
    int               failures;
    int               checked;
    int               found_total;

    initial begin
        failures    = 0;
        checked     = 0;
        found_total = 0;
        grid_step   = STEP_RESET;
    end

    // sine of a whole-degree angle, folded by quadrant
    function automatic longint sine_q15(input int deg);
        int d;
        d = deg % 360;
        if (d <= 90) begin
            return QUARTER_SINE[d];
        end else if (d <= 180) begin
            return QUARTER_SINE[180 - d];
        end else if (d <= 270) begin
            return -QUARTER_SINE[d - 180];
        end
        return -QUARTER_SINE[360 - d];
    endfunction

    function automatic longint cosine_q15(input int deg);
        return sine_q15(deg % 360 + 90);
    endfunction

    // full grid sweep, keeping the first strict minimum below the bound
    function automatic t_out_word sweep_minimum(input t_in_word w, input logic [CFG_W-1:0] step);
        t_out_word r;
        longint    kxx, kxy, kxz, kyy, kyz, kzz;
        longint    sp, z, x, y, acc, e, e_min;
        int        s, p, a, p_min, a_min;
        bit        hit;
        kxx   = $signed(w.k_xx);
        kxy   = $signed(w.k_xy);
        kxz   = $signed(w.k_xz);
        kyy   = $signed(w.k_yy);
        kyz   = $signed(w.k_yz);
        kzz   = $signed(w.k_zz);
        s     = (step == '0) ? 1 : int'(step);
        e_min = ENERGY_BOUND;
        p_min = 0;
        a_min = 0;
        hit   = 1'b0;
        for (p = 0; p <= 180; p += s) begin
            sp = sine_q15(p);
            z  = cosine_q15(p);
            for (a = 0; a <= 360; a += s) begin
                // in-plane direction rounded half up back to Q1.15
                x   = (cosine_q15(a) * sp + HALF_Q15) >>> 15;
                y   = (sine_q15(a) * sp + HALF_Q15) >>> 15;
                acc = kxx * (x * x) + kyy * (y * y) + kzz * (z * z)
                    + kxy * (2 * x * y) + kxz * (2 * x * z) + kyz * (2 * y * z);
                e   = (acc + HALF_ENERGY) >>> 30;
                if (e < e_min) begin
                    e_min = e;
                    p_min = p;
                    a_min = a;
                    hit   = 1'b1;
                end
            end
        end
        // saturate to the 32-bit result field
        if (e_min > WORD_MAX) begin
            e_min = WORD_MAX;
        end else if (e_min < WORD_MIN) begin
            e_min = WORD_MIN;
        end
        r.best_polar   = POL_W'(p_min);
        r.best_azimuth = AZI_W'(a_min);
        r.best_energy  = WORD_W'(e_min);
        r.axis_cosine  = hit ? TRIG_W'(cosine_q15(p_min)) : '0;
        r.height_echo  = w.site_height;
        r.found        = hit;
        return r;
    endfunction

    // count a failure, print only the first few
    task automatic note_failure(input string msg);
        failures++;
        if (failures <= SHOWN_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            note_failure($sformatf("result %0d field %s expected %0d got %0d",
                                   checked, name, $signed(want), $signed(got)));
        end
    endtask

    // watch config writes, accepted words and result strobes
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            grid_step = STEP_RESET;
            pending_minima.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                grid_step = i_cfg_data;
            end
            if (i_result_strobe) begin
                if (pending_minima.size() == 0) begin
                    note_failure($sformatf("result word with nothing expected: %p", i_result));
                end else begin
                    want = pending_minima.pop_front();
                    check_field("best_polar",   want.best_polar,   i_result.best_polar);
                    check_field("best_azimuth", want.best_azimuth, i_result.best_azimuth);
                    check_field("best_energy",  want.best_energy,  i_result.best_energy);
                    check_field("axis_cosine",  want.axis_cosine,  i_result.axis_cosine);
                    check_field("height_echo",  want.height_echo,  i_result.height_echo);
                    check_field("found",        want.found,        i_result.found);
                    checked++;
                    if (want.found) begin
                        found_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_minima.insert(pending_minima.size(), sweep_minimum(i_item, grid_step));
            end
        end
        o_failures <= failures;
        o_pending  <= pending_minima.size();
        o_checked  <= checked;
        o_found    <= found_total;
    end

endmodule

// File: tb/sv/anisotropy_easy_axis_search_top_tb.sv
// testbench top for the easy-axis search: stimulus, step settings and verdict
`timescale 1ns / 1ps
module anisotropy_easy_axis_search_top_tb;
    import aeas_pkg::*;

    localparam int TIMEOUT_NS   = 120_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASES       = 9;
    localparam int PHASE_WORDS  = 22;
    localparam int SMALL_SPAN   = 1 << 20;
    localparam int NOISE_SPAN   = 1 << 14;

    localparam logic signed [WORD_W-1:0] ONE_Q16  = 32'sd65536;
    localparam logic signed [WORD_W-1:0] ISO_HIGH = 32'sd1310720000;
    localparam logic signed [WORD_W-1:0] MAX_WORD = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] MIN_WORD = 32'sh80000000;
    localparam logic signed [WORD_W-1:0] ALT_A    = 32'shaaaaaaaa;
    localparam logic signed [WORD_W-1:0] ALT_5    = 32'sh55555555;

    typedef enum {TENSOR_FULL, TENSOR_SMALL, TENSOR_EASY, TENSOR_HARD, TENSOR_EDGE} t_tensor_kind;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_word         i_item = '0;
    logic             o_result_strobe;
    t_out_word        o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int failures;
    int pending;
    int checked;
    int found_total;
    int words_sent = 0;
    int step_settings = 1;

    anisotropy_easy_axis_search_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    aeas_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_result_strobe (o_result_strobe),
        .i_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_found         (found_total)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_word tensor(
        input logic signed [WORD_W-1:0] xx, xy, xz, yy, yz, zz, h
    );
        t_in_word w;
        w.k_xx        = xx;
        w.k_xy        = xy;
        w.k_xz        = xz;
        w.k_yy        = yy;
        w.k_yz        = yz;
        w.k_zz        = zz;
        w.site_height = h;
        return w;
    endfunction

    function automatic logic signed [WORD_W-1:0] spread(input int span);
        return WORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // random tensor: full range, small, one easy axis, all hard, or near the bound
    function automatic t_in_word random_tensor();
        t_in_word     w;
        t_tensor_kind kind;
        logic signed [WORD_W-1:0] easy;
        case ($urandom_range(0, 9))
            0, 1:    kind = TENSOR_FULL;
            2, 3, 4: kind = TENSOR_SMALL;
            5, 6:    kind = TENSOR_EASY;
            7, 8:    kind = TENSOR_HARD;
            default: kind = TENSOR_EDGE;
        endcase
        case (kind)
            TENSOR_FULL: begin
                w = tensor($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
            end
            TENSOR_SMALL: begin
                w = tensor(spread(SMALL_SPAN), spread(SMALL_SPAN), spread(SMALL_SPAN),
                           spread(SMALL_SPAN), spread(SMALL_SPAN), spread(SMALL_SPAN),
                           $urandom());
            end
            TENSOR_EASY: begin
                w = tensor(spread(NOISE_SPAN), spread(NOISE_SPAN), spread(NOISE_SPAN),
                           spread(NOISE_SPAN), spread(NOISE_SPAN), spread(NOISE_SPAN),
                           $urandom());
                easy = -(ONE_Q16 * $urandom_range(1, 8));
                case ($urandom_range(0, 2))
                    0:       w.k_xx = easy;
                    1:       w.k_yy = easy;
                    default: w.k_zz = easy;
                endcase
            end
            TENSOR_HARD: begin
                w = tensor($urandom_range(700_000_000, 2147483647), spread(NOISE_SPAN),
                           spread(NOISE_SPAN), $urandom_range(700_000_000, 2147483647),
                           spread(NOISE_SPAN), $urandom_range(700_000_000, 2147483647),
                           $urandom());
            end
            default: begin
                w = tensor(START_BOUND_Q16 + spread(64), spread(16), spread(16),
                           START_BOUND_Q16 + spread(64), spread(16),
                           START_BOUND_Q16 + spread(64), $urandom());
            end
        endcase
        return w;
    endfunction

    // present one word after a gap and hold it until taken
    task automatic send_word(input t_in_word w, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        i_item = w;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // new grid step, only once the block is idle and every result is in
    task automatic write_step(input logic [CFG_W-1:0] step);
        @(negedge i_clk);
        start = 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = step;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        step_settings++;
    endtask

    initial begin
        bit no_gaps;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default step of 5 after reset
        send_word(tensor(0, 0, 0, 0, 0, -ONE_Q16, MAX_WORD), 0);
        send_word(tensor(0, 0, 0, 0, 0, 0, MIN_WORD), 2);

        // widest in-range step: extremes, single axes, ties, no hit, bound edge
        write_step(8'd180);
        send_word(tensor(0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 4));
        send_word(tensor(MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD,
                         MAX_WORD), $urandom_range(0, 4));
        send_word(tensor(MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD,
                         MIN_WORD), $urandom_range(0, 4));
        send_word(tensor(-ONE_Q16, 0, 0, 0, 0, 0, ALT_A), 0);
        send_word(tensor(0, 0, 0, -ONE_Q16, 0, 0, ALT_5), 0);
        send_word(tensor(ISO_HIGH, 0, 0, ISO_HIGH, 0, ISO_HIGH, 1), $urandom_range(0, 4));
        send_word(tensor(-ONE_Q16, 0, 0, -ONE_Q16, 0, -ONE_Q16, -1), $urandom_range(0, 4));
        send_word(tensor(0, 0, ONE_Q16, 0, 0, 0, 0), 0);
        send_word(tensor(ALT_A, ALT_A, ALT_A, ALT_A, ALT_A, ALT_A, ALT_A), 1);
        send_word(tensor(ALT_5, ALT_5, ALT_5, ALT_5, ALT_5, ALT_5, ALT_5), 3);
        send_word(tensor(START_BOUND_Q16, 0, 0, START_BOUND_Q16, 0, START_BOUND_Q16, 7), 4);
        send_word(tensor(MAX_WORD, MIN_WORD, MIN_WORD, MAX_WORD, MIN_WORD, MAX_WORD, 0), 0);

        // step above 180: only polar 0, azimuth 0 and the step itself
        write_step(8'd255);
        send_word(tensor(0, 0, 0, 0, 0, -ONE_Q16, 0), $urandom_range(0, 4));
        send_word(random_tensor(), 0);

        // finest grid, then a zero step that sweeps as a step of one
        write_step(8'd1);
        send_word(tensor(0, -ONE_Q16, 0, 0, 0, 0, ALT_5), $urandom_range(0, 4));
        write_step(8'd0);
        send_word(tensor(0, 0, 0, 0, ONE_Q16, -(ONE_Q16 >>> 1), ALT_A), $urandom_range(0, 4));

        // random phases, coarse steps keep each sweep short
        for (int phase = 0; phase < PHASES; phase++) begin
            write_step(CFG_W'($urandom_range(20, 255)));
            no_gaps = (phase % 3 == 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_tensor(), no_gaps ? 0 : $urandom_range(0, 4));
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Swept %0d tensor words over %0d grid step settings (0, 1, 5, 180, 255, random).",
                 words_sent, step_settings);
        $display("Checked %0d result words, %0d with a minimum below the start bound.",
                 checked, found_total);
        if (failures == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
